[sv/iprla_pkg.sv]
// shared constants, codes and types of the route lookup and arp cache block
package iprla_pkg;

	localparam int ROUTE_ENTRIES = 16;
	localparam int ARP_ENTRIES   = 16;

	localparam int RIDX_W = $clog2(ROUTE_ENTRIES);
	localparam int AIDX_W = $clog2(ARP_ENTRIES);
	localparam int CNT_W  = $clog2(ARP_ENTRIES + 1);

	// request commands
	localparam logic [1:0] CMD_ROUTE_WR = 2'd0;
	localparam logic [1:0] CMD_LEARN    = 2'd1;
	localparam logic [1:0] CMD_FWD      = 2'd2;
	localparam logic [1:0] CMD_NONE     = 2'd3;

	// result status codes
	localparam logic [2:0] STS_WRITTEN = 3'd0;
	localparam logic [2:0] STS_LEARNED = 3'd1;
	localparam logic [2:0] STS_FULL    = 3'd2;
	localparam logic [2:0] STS_SAME    = 3'd3;
	localparam logic [2:0] STS_TTL     = 3'd4;
	localparam logic [2:0] STS_HIT     = 3'd5;
	localparam logic [2:0] STS_MISS    = 3'd6;
	localparam logic [2:0] STS_NOROUTE = 3'd7;

	// broadcast write of one routing slot
	typedef struct packed {
		logic              en;
		logic [RIDX_W-1:0] idx;
		logic [31:0]       dest;
		logic [31:0]       mask;
		logic [3:0]        port;
		logic              valid;
	} route_wr_t;

	// broadcast write of one arp cache entry
	typedef struct packed {
		logic              en;
		logic [AIDX_W-1:0] idx;
		logic [31:0]       ip;
		logic [47:0]       mac;
	} arp_wr_t;

	// route search token handed from cell to cell
	typedef struct packed {
		logic        valid;
		logic [31:0] dst;
		logic        match_f;
		logic [31:0] match_dest;
		logic [3:0]  match_port;
		logic        dflt_f;
		logic [31:0] dflt_dest;
		logic [3:0]  dflt_port;
		logic        first_f;
		logic [31:0] first_dest;
		logic [3:0]  first_port;
	} route_srch_t;

	// arp search token handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [31:0]      hop;
		logic [CNT_W-1:0] left;
		logic             hit;
		logic [47:0]      mac;
	} arp_srch_t;

	// one finished result
	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] hop;
		logic [3:0]  port;
		logic [47:0] mac;
		logic        used;
	} result_t;

endpackage

[sv/iprla_route_cell.sv]
// one routing slot with its stage of the route search chain
module iprla_route_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [iprla_pkg::RIDX_W-1:0] cell_idx,
	input  iprla_pkg::route_wr_t       wr,
	input  iprla_pkg::route_srch_t     srch_in,
	output iprla_pkg::route_srch_t     srch_out
);

	logic [31:0] dest_q;
	logic [31:0] mask_q;
	logic [3:0]  port_q;
	logic        valid_q;
	iprla_pkg::route_srch_t srch_nxt;
	iprla_pkg::route_srch_t srch_s1;

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == cell_idx)) begin
			dest_q <= wr.dest;
			mask_q <= wr.mask;
			port_q <= wr.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && (wr.idx == cell_idx)) begin
			valid_q <= wr.valid;
		end
	end

	always_comb begin
		srch_nxt = srch_in;
		if (valid_q) begin
			if (!srch_in.first_f) begin
				srch_nxt.first_f    = 1'b1;
				srch_nxt.first_dest = dest_q;
				srch_nxt.first_port = port_q;
			end
			// default entries: the last one wins
			if (dest_q == 32'd0) begin
				srch_nxt.dflt_f    = 1'b1;
				srch_nxt.dflt_dest = dest_q;
				srch_nxt.dflt_port = port_q;
			end else if (!srch_in.match_f && ((srch_in.dst & mask_q) == dest_q)) begin
				srch_nxt.match_f    = 1'b1;
				srch_nxt.match_dest = dest_q;
				srch_nxt.match_port = port_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		srch_s1 <= srch_nxt;
	end

	// only the token's valid needs a reset
	logic vld_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= srch_in.valid;
		end
	end

	always_comb begin
		srch_out       = srch_s1;
		srch_out.valid = vld_s1;
	end

endmodule

[sv/iprla_arp_cell.sv]
// one arp cache entry with its stage of the arp search chain
module iprla_arp_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [iprla_pkg::AIDX_W-1:0] cell_idx,
	input  iprla_pkg::arp_wr_t           wr,
	input  iprla_pkg::arp_srch_t         srch_in,
	output iprla_pkg::arp_srch_t         srch_out
);

	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic        live;
	iprla_pkg::arp_srch_t srch_nxt;
	iprla_pkg::arp_srch_t srch_s1;
	logic                 vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == cell_idx)) begin
			ip_q  <= wr.ip;
			mac_q <= wr.mac;
		end
	end

	// entry counts only while it is below the fill count
	assign live = (srch_in.left != '0);

	always_comb begin
		srch_nxt = srch_in;
		if (live) begin
			srch_nxt.left = srch_in.left - iprla_pkg::CNT_W'(1);
			if (!srch_in.hit && (ip_q == srch_in.hop)) begin
				srch_nxt.hit = 1'b1;
				srch_nxt.mac = mac_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		srch_s1 <= srch_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= srch_in.valid;
		end
	end

	always_comb begin
		srch_out       = srch_s1;
		srch_out.valid = vld_s1;
	end

endmodule

[sv/ip_route_lookup_arp_cache_top.sv]
// top level of the ip route lookup and arp cache block
//
// forwarding decision engine: a route write (cmd 0) and an arp learn (cmd 1) are
// answered from idle through the pending result and the output register; a
// forward request (cmd 2) with equal addresses or a zero ttl is answered the same
// way. a real lookup walks a token down a chain of ROUTE_ENTRIES route cells (one
// slot per cell, one cell per cycle) and then down a chain of ARP_ENTRIES arp
// cells, and the result then passes the pending result and output registers. one
// request is in work at a time, but a finished result can sit in the output
// register while the next request is taken. cmd 3 is taken and ignored. the arp
// cache is filled in order; once full, learns answer cache full and store nothing.
// route and cache contents need no clearing after reset.
module ip_route_lookup_arp_cache_top (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  route_index,
	input  logic [31:0] route_dest,
	input  logic [31:0] route_mask,
	input  logic [3:0]  route_port,
	input  logic        route_valid,
	input  logic [31:0] learn_ip,
	input  logic [47:0] learn_mac,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [7:0]  ttl,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] next_hop_ip,
	output logic [3:0]  out_port,
	output logic [47:0] next_hop_mac,
	output logic        used_default
);

	localparam int R = iprla_pkg::ROUTE_ENTRIES;
	localparam int A = iprla_pkg::ARP_ENTRIES;

	// controller states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUTE = 2'd1;
	localparam logic [1:0] ST_ARP   = 2'd2;
	localparam logic [1:0] ST_RESP  = 2'd3;

	logic [1:0] state_q, state_nxt;
	logic [iprla_pkg::CNT_W-1:0] count_q;
	iprla_pkg::result_t res_q, res_nxt;
	logic        res_ld;
	logic [31:0] hop_q;
	logic [3:0]  port_q;
	logic        used_q;
	logic        sel_ld;
	logic [31:0] sel_hop;
	logic [3:0]  sel_port;
	logic        sel_used;
	logic        sel_none;

	logic        out_valid_q;
	iprla_pkg::result_t out_q;

	logic accept;
	logic out_free;
	logic cache_full;
	logic route_in_range;

	iprla_pkg::route_wr_t   rwr;
	iprla_pkg::arp_wr_t     awr;
	iprla_pkg::route_srch_t rchain [R+1];
	iprla_pkg::arp_srch_t   achain [A+1];
	logic [R-1:0]           rvld;

	assign accept         = in_valid && !in_stall;
	assign in_stall       = (state_q != ST_IDLE);
	assign out_free       = !out_valid_q || !out_stall;
	assign cache_full     = (count_q >= iprla_pkg::CNT_W'(A));
	assign route_in_range = ({28'd0, route_index} < 32'(R));

	// broadcast writes into the cells, done at the accepting edge
	always_comb begin
		rwr.en    = accept && (cmd == iprla_pkg::CMD_ROUTE_WR) && route_in_range;
		rwr.idx   = iprla_pkg::RIDX_W'(route_index);
		rwr.dest  = route_dest;
		rwr.mask  = route_mask;
		rwr.port  = route_port;
		rwr.valid = route_valid;
		awr.en    = accept && (cmd == iprla_pkg::CMD_LEARN) && !cache_full;
		awr.idx   = count_q[iprla_pkg::AIDX_W-1:0];
		awr.ip    = learn_ip;
		awr.mac   = learn_mac;
	end

	// route search token enters the chain on a forward request that passes the checks
	always_comb begin
		rchain[0]       = '0;
		rchain[0].valid = accept && (cmd == iprla_pkg::CMD_FWD) && (src_ip != dst_ip)
			&& (ttl != 8'd0);
		rchain[0].dst   = dst_ip;
	end

	genvar gi;
	generate
		for (gi = 0; gi < R; gi++) begin : g_route
			iprla_route_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cell_idx (iprla_pkg::RIDX_W'(gi)),
				.wr       (rwr),
				.srch_in  (rchain[gi]),
				.srch_out (rchain[gi+1])
			);
			assign rvld[gi] = rchain[gi+1].valid;
		end
		for (gi = 0; gi < A; gi++) begin : g_arp
			iprla_arp_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cell_idx (iprla_pkg::AIDX_W'(gi)),
				.wr       (awr),
				.srch_in  (achain[gi]),
				.srch_out (achain[gi+1])
			);
		end
	endgenerate

	// route choice at the chain end: match, then last default, then first valid
	always_comb begin
		sel_none = 1'b0;
		sel_used = 1'b1;
		sel_hop  = rchain[R].first_dest;
		sel_port = rchain[R].first_port;
		if (rchain[R].match_f) begin
			sel_used = 1'b0;
			sel_hop  = rchain[R].match_dest;
			sel_port = rchain[R].match_port;
		end else if (rchain[R].dflt_f) begin
			sel_hop  = rchain[R].dflt_dest;
			sel_port = rchain[R].dflt_port;
		end else if (!rchain[R].first_f) begin
			sel_none = 1'b1;
		end
	end

	// arp token enters as the route token leaves
	always_comb begin
		achain[0]       = '0;
		achain[0].valid = (state_q == ST_ROUTE) && rchain[R].valid && !sel_none;
		achain[0].hop   = sel_hop;
		achain[0].left  = count_q;
	end

	// controller
	always_comb begin
		state_nxt = state_q;
		res_nxt   = '0;
		res_ld    = 1'b0;
		sel_ld    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						iprla_pkg::CMD_ROUTE_WR: begin
							res_nxt.status = iprla_pkg::STS_WRITTEN;
							res_ld         = 1'b1;
							state_nxt      = ST_RESP;
						end
						iprla_pkg::CMD_LEARN: begin
							res_nxt.status = cache_full ? iprla_pkg::STS_FULL
								: iprla_pkg::STS_LEARNED;
							res_ld         = 1'b1;
							state_nxt      = ST_RESP;
						end
						iprla_pkg::CMD_FWD: begin
							if (src_ip == dst_ip) begin
								res_nxt.status = iprla_pkg::STS_SAME;
								res_ld         = 1'b1;
								state_nxt      = ST_RESP;
							end else if (ttl == 8'd0) begin
								res_nxt.status = iprla_pkg::STS_TTL;
								res_ld         = 1'b1;
								state_nxt      = ST_RESP;
							end else begin
								state_nxt = ST_ROUTE;
							end
						end
						default: begin
							// unused command, no result
							state_nxt = ST_IDLE;
						end
					endcase
				end
			end
			ST_ROUTE: begin
				if (rchain[R].valid) begin
					if (sel_none) begin
						res_nxt.status = iprla_pkg::STS_NOROUTE;
						res_ld         = 1'b1;
						state_nxt      = ST_RESP;
					end else begin
						sel_ld    = 1'b1;
						state_nxt = ST_ARP;
					end
				end
			end
			ST_ARP: begin
				if (achain[A].valid) begin
					res_nxt.status = achain[A].hit ? iprla_pkg::STS_HIT : iprla_pkg::STS_MISS;
					res_nxt.hop    = hop_q;
					res_nxt.port   = port_q;
					res_nxt.mac    = achain[A].hit ? achain[A].mac : 48'd0;
					res_nxt.used   = used_q;
					res_ld         = 1'b1;
					state_nxt      = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (awr.en) begin
				count_q <= count_q + iprla_pkg::CNT_W'(1);
			end
		end
	end

	// pending result and selected route
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_nxt;
		end
		if (sel_ld) begin
			hop_q  <= sel_hop;
			port_q <= sel_port;
			used_q <= sel_used;
		end
	end

	// output register, loaded from the pending result when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign next_hop_ip  = out_q.hop;
	assign out_port     = out_q.port;
	assign next_hop_mac = out_q.mac;
	assign used_default = out_q.used;

	// route token leaves the chain only while the controller waits for it
	a_route_end: assert property (@(posedge clk) disable iff (!arst_n)
		rchain[R].valid |-> (state_q == ST_ROUTE))
		else $error("route token out of step with controller");

	// arp token leaves the chain only while the controller waits for it
	a_arp_end: assert property (@(posedge clk) disable iff (!arst_n)
		achain[A].valid |-> (state_q == ST_ARP))
		else $error("arp token out of step with controller");

	// at most one token in the route chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(rvld))
		else $error("more than one route token in flight");

	// fill count never passes the cache size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= iprla_pkg::CNT_W'(A))
		else $error("arp fill count overflow");

	// a used command leaves idle on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd != iprla_pkg::CMD_NONE)) |=> (state_q != ST_IDLE))
		else $error("request taken without work");

endmodule

[sim/testbench.sv]
// self-checking testbench for the ip route lookup and arp cache block
`timescale 1ns / 100ps

module testbench;

	// one request as the sender sees it
	typedef struct {
		logic [1:0]  cmd;
		logic [3:0]  index;
		logic [31:0] dest;
		logic [31:0] mask;
		logic [3:0]  port;
		logic        valid;
		logic [31:0] lip;
		logic [47:0] lmac;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  ttl;
	} req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [3:0]  route_index;
	logic [31:0] route_dest;
	logic [31:0] route_mask;
	logic [3:0]  route_port;
	logic        route_valid;
	logic [31:0] learn_ip;
	logic [47:0] learn_mac;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [7:0]  ttl;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] next_hop_ip;
	logic [3:0]  out_port;
	logic [47:0] next_hop_mac;
	logic        used_default;

	ip_route_lookup_arp_cache_top uut (.*);

	// our own copy of the routing table and arp cache
	logic [31:0] rt_dest [iprla_pkg::ROUTE_ENTRIES];
	logic [31:0] rt_mask [iprla_pkg::ROUTE_ENTRIES];
	logic [3:0]  rt_port [iprla_pkg::ROUTE_ENTRIES];
	logic        rt_on   [iprla_pkg::ROUTE_ENTRIES];
	logic [31:0] arp_ip  [iprla_pkg::ARP_ENTRIES];
	logic [47:0] arp_mac [iprla_pkg::ARP_ENTRIES];
	int          arp_fill;

	// results still owed by the block, oldest first
	iprla_pkg::result_t decision_q [$];
	int          err_count;
	bit          idle_on;

	// network pool used to aim random packets at real routes
	logic [31:0] net_pool  [8];
	logic [31:0] mask_pool [8];

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the handshake hangs
	initial begin
		#10_000_000;
		$display("[ip_route_lookup_arp_cache_top] ERROR");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		if (err_count < 100)
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		err_count++;
	endtask

	// updates the shadow state for one taken request and works out its result;
	// returns 0 when the request produces no result (unused command)
	function automatic bit apply_request(input req_t r, output iprla_pkg::result_t res);
		int i;
		int match_slot;
		int dflt_slot;
		int first_slot;
		int sel;
		res = '0;
		match_slot = -1;
		dflt_slot = -1;
		first_slot = -1;
		sel = -1;
		case (r.cmd)
		iprla_pkg::CMD_ROUTE_WR: begin
			if (r.index < iprla_pkg::ROUTE_ENTRIES) begin
				rt_dest[r.index] = r.dest;
				rt_mask[r.index] = r.mask;
				rt_port[r.index] = r.port;
				rt_on[r.index] = r.valid;
			end
			res.status = iprla_pkg::STS_WRITTEN;
		end
		iprla_pkg::CMD_LEARN: begin
			if (arp_fill < iprla_pkg::ARP_ENTRIES) begin
				arp_ip[arp_fill] = r.lip;
				arp_mac[arp_fill] = r.lmac;
				arp_fill++;
				res.status = iprla_pkg::STS_LEARNED;
			end else begin
				res.status = iprla_pkg::STS_FULL;
			end
		end
		iprla_pkg::CMD_FWD: begin
			if (r.src == r.dst) begin
				res.status = iprla_pkg::STS_SAME;
			end else if (r.ttl == 8'd0) begin
				res.status = iprla_pkg::STS_TTL;
			end else begin
				for (i = 0; i < iprla_pkg::ROUTE_ENTRIES; i++) begin
					if (rt_on[i]) begin
						if (first_slot < 0)
							first_slot = i;
						if (rt_dest[i] == 32'd0)
							dflt_slot = i;
						else if (match_slot < 0 && (r.dst & rt_mask[i]) == rt_dest[i])
							match_slot = i;
					end
				end
				if (match_slot >= 0) begin
					sel = match_slot;
				end else if (dflt_slot >= 0) begin
					sel = dflt_slot;
					res.used = 1'b1;
				end else if (first_slot >= 0) begin
					sel = first_slot;
					res.used = 1'b1;
				end
				if (sel < 0) begin
					res.status = iprla_pkg::STS_NOROUTE;
				end else begin
					res.hop = rt_dest[sel];
					res.port = rt_port[sel];
					res.status = iprla_pkg::STS_MISS;
					// earliest cache entry wins when an address was learned twice
					for (i = 0; i < arp_fill; i++) begin
						if (arp_ip[i] == res.hop) begin
							res.status = iprla_pkg::STS_HIT;
							res.mac = arp_mac[i];
							break;
						end
					end
				end
			end
		end
		default: begin
			return 1'b0;
		end
		endcase
		return 1'b1;
	endfunction

	// every field random, so fields the command ignores still toggle
	function automatic req_t noise_req();
		req_t r;
		logic [63:0] w;
		w = {$urandom, $urandom};
		r.cmd = 2'($urandom_range(0, 3));
		r.index = 4'($urandom);
		r.dest = $urandom;
		r.mask = $urandom;
		r.port = 4'($urandom);
		r.valid = 1'($urandom);
		r.lip = $urandom;
		r.lmac = w[47:0];
		r.src = $urandom;
		r.dst = $urandom;
		r.ttl = 8'($urandom);
		return r;
	endfunction

	function automatic req_t route_req(input logic [3:0] idx, input logic [31:0] dest,
		input logic [31:0] mask, input logic [3:0] port, input logic valid);
		req_t r;
		r = noise_req();
		r.cmd = iprla_pkg::CMD_ROUTE_WR;
		r.index = idx;
		r.dest = dest;
		r.mask = mask;
		r.port = port;
		r.valid = valid;
		return r;
	endfunction

	function automatic req_t learn_req(input logic [31:0] ip, input logic [47:0] mac);
		req_t r;
		r = noise_req();
		r.cmd = iprla_pkg::CMD_LEARN;
		r.lip = ip;
		r.lmac = mac;
		return r;
	endfunction

	function automatic req_t fwd_req(input logic [31:0] src, input logic [31:0] dst,
		input logic [7:0] t);
		req_t r;
		r = noise_req();
		r.cmd = iprla_pkg::CMD_FWD;
		r.src = src;
		r.dst = dst;
		r.ttl = t;
		return r;
	endfunction

	// drive one request and hold it until the block takes it; valid is only
	// lowered when an idle gap is drawn, so back-to-back requests keep it high
	task automatic send_request(input req_t r);
		int unsigned gap;
		iprla_pkg::result_t res;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= r.cmd;
		route_index <= r.index;
		route_dest <= r.dest;
		route_mask <= r.mask;
		route_port <= r.port;
		route_valid <= r.valid;
		learn_ip <= r.lip;
		learn_mac <= r.lmac;
		src_ip <= r.src;
		dst_ip <= r.dst;
		ttl <= r.ttl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// taken at this edge: predict now so the shadow state follows the block
		if (apply_request(r, res))
			decision_q.push_back(res);
	endtask

	// result side: draw a stall per result, then take and check one result
	initial begin : result_check
		iprla_pkg::result_t want;
		int unsigned hold;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = idle_on ? $urandom_range(0, 19) : 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (decision_q.size() == 0) begin
				report("unexpected result status", 64'(status), '0);
			end else begin
				want = decision_q.pop_front();
				if (status !== want.status)
					report("status", 64'(status), 64'(want.status));
				if (next_hop_ip !== want.hop)
					report("next_hop_ip", 64'(next_hop_ip), 64'(want.hop));
				if (out_port !== want.port)
					report("out_port", 64'(out_port), 64'(want.port));
				if (next_hop_mac !== want.mac)
					report("next_hop_mac", 64'(next_hop_mac), 64'(want.mac));
				if (used_default !== want.used)
					report("used_default", 64'(used_default), 64'(want.used));
			end
		end
	end

	// empty table: no route, and the header checks in their priority order
	task automatic test_empty_table();
		req_t r;
		idle_on = 1'b0;
		send_request(fwd_req(32'h0000_0001, 32'h0000_0002, 8'd64));
		send_request(fwd_req(32'h0000_0005, 32'h0000_0005, 8'd0));
		send_request(fwd_req(32'h0000_0001, 32'h0000_0002, 8'd0));
		r = noise_req();
		r.cmd = iprla_pkg::CMD_NONE;
		send_request(r);
		send_request(fwd_req(32'hFFFF_FFFF, 32'h0000_0000, 8'd255));
	endtask

	// route selection: exact match, last default, then first valid slot
	task automatic test_route_select();
		idle_on = 1'b1;
		send_request(route_req(4'd0, 32'hC0A8_0100, 32'hFFFF_FF00, 4'd3, 1'b0));
		send_request(route_req(4'd1, 32'h0A00_0000, 32'hFF00_0000, 4'd1, 1'b1));
		send_request(route_req(4'd4, 32'h0000_0000, 32'h0000_0000, 4'd4, 1'b1));
		send_request(route_req(4'd9, 32'h0000_0000, 32'h0000_0000, 4'd9, 1'b1));
		send_request(route_req(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1));
		send_request(fwd_req(32'h0000_0001, 32'h0A0B_0C0D, 8'd1));
		send_request(fwd_req(32'h0000_0002, 32'hFFFF_FFFF, 8'd255));
		// slot 0 would match but is inactive, so the later default is taken
		send_request(fwd_req(32'h0000_0003, 32'hC0A8_0105, 8'd8));
		send_request(route_req(4'd9, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b0));
		send_request(route_req(4'd4, 32'h0000_0000, 32'h0000_0000, 4'd0, 1'b0));
		// no default left: first active slot is the fallback
		send_request(fwd_req(32'h0000_0003, 32'hC0A8_0105, 8'd8));
	endtask

	// arp cache: hits, duplicate learn, zero and all-ones addresses
	task automatic test_arp_lookup();
		idle_on = 1'b1;
		send_request(learn_req(32'h0A00_0000, 48'h1234_5678_9ABC));
		send_request(learn_req(32'h0A00_0000, 48'hFFFF_FFFF_FFFF));
		send_request(learn_req(32'hFFFF_FFFF, 48'h0000_0000_0000));
		send_request(learn_req(32'h0000_0000, 48'hFFFF_FFFF_FFFF));
		send_request(fwd_req(32'h0000_0007, 32'h0A00_0001, 8'd100));
		send_request(fwd_req(32'h0000_0007, 32'hFFFF_FFFF, 8'd1));
		send_request(route_req(4'd4, 32'h0000_0000, 32'h0000_0000, 4'd4, 1'b1));
		send_request(fwd_req(32'h0000_0007, 32'hC0A8_0105, 8'd2));
	endtask

	// random traffic aimed at a small set of networks so matches and hits are common
	task automatic test_random();
		req_t r;
		int counted;
		int i;
		int unsigned len;
		int unsigned pick;
		int unsigned roll;
		for (i = 0; i < 8; i++) begin
			len = (i == 7) ? 32 : $urandom_range(8, 28);
			mask_pool[i] = 32'hFFFF_FFFF << (32 - len);
			net_pool[i] = $urandom & mask_pool[i];
			if (net_pool[i] == 32'd0)
				net_pool[i] = mask_pool[i];
		end
		counted = 0;
		idle_on = 1'b1;
		while (counted < 1600) begin
			// alternate stretches with and without idle cycles
			if (counted % 200 == 0)
				idle_on = (counted / 200) % 2 == 0;
			r = noise_req();
			pick = $urandom_range(0, 7);
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				r.cmd = iprla_pkg::CMD_ROUTE_WR;
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					r.dest = net_pool[pick];
					r.mask = mask_pool[pick];
				end else if (roll < 85) begin
					r.dest = 32'd0;
				end
				r.valid = $urandom_range(0, 99) < 85;
			end else if (roll < 40) begin
				r.cmd = iprla_pkg::CMD_LEARN;
				roll = $urandom_range(0, 99);
				if (roll < 70)
					r.lip = net_pool[pick];
				else if (roll < 80)
					r.lip = 32'd0;
			end else if (roll < 95) begin
				r.cmd = iprla_pkg::CMD_FWD;
				if ($urandom_range(0, 99) < 75)
					r.dst = net_pool[pick] | (r.dst & ~mask_pool[pick]);
				if ($urandom_range(0, 99) < 5)
					r.src = r.dst;
				if ($urandom_range(0, 99) < 5)
					r.ttl = 8'd0;
			end else begin
				r.cmd = iprla_pkg::CMD_NONE;
			end
			send_request(r);
			if (r.cmd != iprla_pkg::CMD_NONE)
				counted++;
		end
	endtask

	// fill the cache to the top, learn past it, then look up an early entry
	task automatic test_cache_full();
		idle_on = 1'b1;
		while (arp_fill < iprla_pkg::ARP_ENTRIES)
			send_request(learn_req($urandom, 48'hABCD_0000_0000 | 48'(arp_fill)));
		send_request(learn_req(32'h0A00_0000, 48'h0000_1111_2222));
		send_request(learn_req($urandom, 48'h0000_3333_4444));
		send_request(route_req(4'd0, 32'h0A00_0000, 32'hFF00_0000, 4'd6, 1'b1));
		send_request(fwd_req(32'h0000_0009, 32'h0A12_3456, 8'd33));
	endtask

	// reset, run the tests in turn, drain and decide
	initial begin : main
		int i;
		for (i = 0; i < iprla_pkg::ROUTE_ENTRIES; i++)
			rt_on[i] = 1'b0;
		arp_fill = 0;
		err_count = 0;
		idle_on = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= iprla_pkg::CMD_NONE;
		route_index <= '0;
		route_dest <= '0;
		route_mask <= '0;
		route_port <= '0;
		route_valid <= 1'b0;
		learn_ip <= '0;
		learn_mac <= '0;
		src_ip <= '0;
		dst_ip <= '0;
		ttl <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_route_select();
		test_arp_lookup();
		test_random();
		test_cache_full();

		in_valid <= 1'b0;
		while (decision_q.size() != 0) @(posedge clk);
		// watch a while longer so a stray extra result is caught
		repeat (iprla_pkg::ROUTE_ENTRIES + iprla_pkg::ARP_ENTRIES + 8) @(posedge clk);
		if (err_count == 0)
			$display("[ip_route_lookup_arp_cache_top] OK");
		else
			$display("[ip_route_lookup_arp_cache_top] ERROR");
		$finish;
	end

endmodule

[filelist.f]
sv/iprla_pkg.sv
sv/iprla_route_cell.sv
sv/iprla_arp_cell.sv
sv/ip_route_lookup_arp_cache_top.sv
sim/testbench.sv
